// ===== rtl/glmf_pkg.sv =====
// Shared types and constants of the grid local maximum finder.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package glmf_pkg;

    localparam int MAX_COLS      = 128;
    localparam int SAMPLE_BITS   = 16;
    localparam int ROW_BITS      = 12;
    localparam int NUM_ROWS_BITS = 13;
    localparam int NUM_COLS_BITS = 8;
    localparam int ROWS_LIMIT    = 4096;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam int QUEUE_DEPTH   = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS = 1'b1;

    // Request commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'b001,
        PH_FLUSH = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    // What the back end does with one queued request
    typedef struct packed {
        logic is_sample;
        logic decide;
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
    } act_flags_t;

endpackage

`default_nettype wire

// ===== rtl/grid_local_maximum_finder.sv =====
// Grid local maximum finder, 4-neighbor, raster order. Accepts one request per
// cycle unless in_stall; requests pass queue, execute stage and result register.
// Throughput is set by the single read port of each of the two line store
// copies: one center read and one right-neighbor read per cycle.
// Reset clears position, phase, queue and sizes (1 x 1); the line stores are
// not cleared and need no clearing pass.
// Uses glmf_pkg, glmf_front, glmf_queue, glmf_back and glmf_ram.
`default_nettype none

module grid_local_maximum_finder #(
    parameter int MAX_COLS    = glmf_pkg::MAX_COLS,
    parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [glmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [glmf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [SAMPLE_BITS-1:0]             pixel_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [glmf_pkg::ROW_BITS-1:0]           peak_row,
    output logic [$clog2(MAX_COLS)-1:0]             peak_col
);

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int RB       = glmf_pkg::ROW_BITS;
    localparam int FB       = $bits(glmf_pkg::act_flags_t);
    localparam int QW       = FB + COL_BITS + RB + SAMPLE_BITS;

    logic                 push, q_full, q_valid, q_pop;
    glmf_pkg::act_flags_t push_flags, q_flags;
    logic [COL_BITS-1:0]  push_col, q_col;
    logic [RB-1:0]        push_row, q_row;
    logic [SAMPLE_BITS-1:0] push_sample, q_sample;
    logic [QW-1:0]        push_data, pop_data;

    assign in_stall = q_full;

    glmf_front #(.MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pixel_value (pixel_value),
        .q_full      (q_full),
        .push        (push),
        .push_flags  (push_flags),
        .push_col    (push_col),
        .push_row    (push_row),
        .push_sample (push_sample)
    );

    assign push_data = {push_flags, push_col, push_row, push_sample};

    glmf_queue #(.WIDTH(QW), .DEPTH(glmf_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_data  (pop_data)
    );

    assign {q_flags, q_col, q_row, q_sample} = pop_data;

    glmf_back #(.MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_flags   (q_flags),
        .q_col     (q_col),
        .q_row     (q_row),
        .q_sample  (q_sample),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .peak_row  (peak_row),
        .peak_col  (peak_col)
    );

endmodule

`default_nettype wire

// ===== rtl/glmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is enabled. No dependencies.
`default_nettype none

module glmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/glmf_front.sv =====
// Front end: configuration registers, raster position tracking and request
// classification. Uses glmf_pkg; feeds glmf_queue.
`default_nettype none

module glmf_front #(
    parameter int MAX_COLS    = glmf_pkg::MAX_COLS,
    parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [glmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [glmf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               command,
    input  wire logic [SAMPLE_BITS-1:0]             pixel_value,
    input  wire logic                               q_full,
    output logic                                    push,
    output glmf_pkg::act_flags_t                    push_flags,
    output logic [$clog2(MAX_COLS)-1:0]             push_col,
    output logic [glmf_pkg::ROW_BITS-1:0]           push_row,
    output logic [SAMPLE_BITS-1:0]                  push_sample
);

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int RB       = glmf_pkg::ROW_BITS;
    localparam int CXW      = (COL_BITS + 1 > glmf_pkg::NUM_COLS_BITS + 1) ?
                              COL_BITS + 1 : glmf_pkg::NUM_COLS_BITS + 1;

    logic [glmf_pkg::NUM_ROWS_BITS-1:0] num_rows_reg;
    logic [glmf_pkg::NUM_COLS_BITS-1:0] num_cols_reg;
    logic [RB-1:0]                      row_counter_reg, row_counter_next;
    logic [COL_BITS-1:0]                col_counter_reg, col_counter_next;
    glmf_pkg::phase_t                   phase_reg, phase_next;

    logic [RB-1:0]       rows_m1, r_cl;
    logic [COL_BITS-1:0] cols_m1, c_cl;
    logic [CXW-1:0]      num_cols_x;
    logic                accept, load_sample, flush_tick, last_col, last_row;

    always_comb
    begin
        if (num_rows_reg == '0)
            rows_m1 = '0;
        else if (num_rows_reg > glmf_pkg::NUM_ROWS_BITS'(glmf_pkg::ROWS_LIMIT))
            rows_m1 = RB'(glmf_pkg::ROWS_LIMIT - 1);
        else
            rows_m1 = RB'(num_rows_reg - glmf_pkg::NUM_ROWS_BITS'(1));

        num_cols_x = CXW'(num_cols_reg);
        if (num_cols_reg == '0)
            cols_m1 = '0;
        else if (num_cols_x > CXW'(MAX_COLS))
            cols_m1 = COL_BITS'(MAX_COLS - 1);
        else
            cols_m1 = COL_BITS'(num_cols_x - CXW'(1));
    end

    // Clamp the position in case the sizes shrank since the last request
    assign r_cl     = (row_counter_reg > rows_m1) ? rows_m1 : row_counter_reg;
    assign c_cl     = (col_counter_reg > cols_m1) ? cols_m1 : col_counter_reg;
    assign last_col = (c_cl == cols_m1);
    assign last_row = (r_cl == rows_m1);

    assign accept      = in_valid && !in_stall;
    assign load_sample = (phase_reg == glmf_pkg::PH_LOAD) && (command == glmf_pkg::CMD_SAMPLE);
    assign flush_tick  = (phase_reg == glmf_pkg::PH_FLUSH) && (command == glmf_pkg::CMD_FLUSH);

    // Drop requests that do not fit the phase
    assign push = accept && (load_sample || flush_tick);

    always_comb
    begin
        push_flags.is_sample = load_sample;
        push_flags.decide    = flush_tick || (r_cl != '0);
        push_flags.has_left  = (c_cl != '0);
        push_flags.has_right = !last_col;
        push_flags.has_up    = load_sample ? (r_cl >= RB'(2)) : (r_cl != '0);
        push_flags.has_down  = load_sample;
        push_col             = c_cl;
        push_row             = load_sample ? (r_cl - RB'(1)) : r_cl;
        push_sample          = pixel_value;
    end

    always_comb
    begin
        row_counter_next = row_counter_reg;
        col_counter_next = col_counter_reg;
        phase_next       = phase_reg;
        if (push)
        begin
            row_counter_next = r_cl;
            if (last_col)
            begin
                col_counter_next = '0;
                if (flush_tick)
                    phase_next = glmf_pkg::PH_DONE;
                else if (last_row)
                    phase_next = glmf_pkg::PH_FLUSH;
                else
                    row_counter_next = r_cl + RB'(1);
            end
            else
            begin
                col_counter_next = c_cl + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= glmf_pkg::NUM_ROWS_BITS'(1);
            num_cols_reg    <= glmf_pkg::NUM_COLS_BITS'(1);
            row_counter_reg <= '0;
            col_counter_reg <= '0;
            phase_reg       <= glmf_pkg::PH_LOAD;
        end
        else
        begin
            if (cfg_we && (cfg_index == glmf_pkg::REG_NUM_ROWS))
                num_rows_reg <= cfg_data;
            if (cfg_we && (cfg_index == glmf_pkg::REG_NUM_COLS))
                num_cols_reg <= cfg_data[glmf_pkg::NUM_COLS_BITS-1:0];
            row_counter_reg <= row_counter_next;
            col_counter_reg <= col_counter_next;
            phase_reg       <= phase_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("request pushed into a full queue");

    a_done_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == glmf_pkg::PH_DONE)
        |=> $stable(row_counter_reg) && $stable(col_counter_reg)
            && (phase_reg == glmf_pkg::PH_DONE))
        else $error("position moved after the grid was finished");

    a_flush_starts_left: assert property (@(posedge clk) disable iff (!rst_n)
        push && load_sample && last_col && last_row |=> col_counter_reg == '0)
        else $error("flush did not start at column zero");

endmodule

`default_nettype wire

// ===== rtl/glmf_queue.sv =====
// Short FIFO between the front end and the back end.
// Generic width and depth; no package dependencies.
`default_nettype none

module glmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  not_empty,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/glmf_back.sv =====
// Back end: line store reads, four-neighbor compare, line store update and
// the result register. Uses glmf_pkg and two glmf_ram copies of the lines.
`default_nettype none

module glmf_back #(
    parameter int MAX_COLS    = glmf_pkg::MAX_COLS,
    parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire glmf_pkg::act_flags_t          q_flags,
    input  wire logic [$clog2(MAX_COLS)-1:0]   q_col,
    input  wire logic [glmf_pkg::ROW_BITS-1:0] q_row,
    input  wire logic [SAMPLE_BITS-1:0]        q_sample,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [glmf_pkg::ROW_BITS-1:0]      peak_row,
    output logic [$clog2(MAX_COLS)-1:0]        peak_col
);

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int SB       = SAMPLE_BITS;
    localparam int RB       = glmf_pkg::ROW_BITS;

    logic                 e_valid_reg;
    glmf_pkg::act_flags_t e_flags_reg;
    logic [COL_BITS-1:0]  e_col_reg;
    logic [RB-1:0]        e_row_reg;
    logic [SB-1:0]        e_sample_reg;
    logic                 fwd_c_reg, fwd_r_reg;
    logic [2*SB-1:0]      fwd_entry_reg;
    logic [SB-1:0]        fwd_right_reg;
    logic [SB-1:0]        left_reg;
    logic                 out_valid_reg;
    logic [RB-1:0]        peak_row_reg;
    logic [COL_BITS-1:0]  peak_col_reg;

    logic [2*SB-1:0]      a_rdata, center_entry, wr_entry;
    logic [SB-1:0]        b_rdata;
    logic signed [SB-1:0] center, older, right, left, down;
    logic [SB-1:0]        new_prev, new_older;
    logic [COL_BITS-1:0]  right_addr;
    logic                 out_free, e_fire, issue, peak;

    assign out_free = !out_valid_reg || !out_stall;
    assign e_fire   = e_valid_reg && out_free;
    assign issue    = q_valid && (!e_valid_reg || e_fire);
    assign q_pop    = issue;

    assign right_addr = q_col + COL_BITS'(1);

    // Entry holds {older row, previous row} of one column
    glmf_ram #(.WIDTH(2 * SB), .DEPTH(MAX_COLS)) u_ram_center (
        .clk   (clk),
        .we    (e_fire),
        .waddr (e_col_reg),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (q_col),
        .rdata (a_rdata)
    );

    // Copy of the previous row for the right-hand neighbor read
    glmf_ram #(.WIDTH(SB), .DEPTH(MAX_COLS)) u_ram_right (
        .clk   (clk),
        .we    (e_fire),
        .waddr (e_col_reg),
        .wdata (new_prev),
        .re    (issue),
        .raddr (right_addr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        center_entry = fwd_c_reg ? fwd_entry_reg : a_rdata;
        center       = center_entry[SB-1:0];
        older        = center_entry[2*SB-1:SB];
        right        = fwd_r_reg ? fwd_right_reg : b_rdata;
        left         = left_reg;
        down         = e_sample_reg;

        peak = !(e_flags_reg.has_left  && (center < left))
            && !(e_flags_reg.has_right && (center < right))
            && !(e_flags_reg.has_up    && (center < older))
            && !(e_flags_reg.has_down  && (center < down));

        new_prev  = e_flags_reg.is_sample ? e_sample_reg : center;
        new_older = e_flags_reg.decide ? center : older;
        wr_entry  = {new_older, new_prev};
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            e_flags_reg   <= q_flags;
            e_col_reg     <= q_col;
            e_row_reg     <= q_row;
            e_sample_reg  <= q_sample;
            // Bypass the line store when the entry is written in this cycle
            fwd_c_reg     <= e_fire && (e_col_reg == q_col);
            fwd_r_reg     <= e_fire && (e_col_reg == right_addr);
            fwd_entry_reg <= wr_entry;
            fwd_right_reg <= new_prev;
        end
        if (e_fire)
        begin
            peak_row_reg <= e_row_reg;
            peak_col_reg <= e_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (issue)
                e_valid_reg <= 1'b1;
            else if (e_fire)
                e_valid_reg <= 1'b0;

            if (e_fire)
                out_valid_reg <= e_flags_reg.decide && peak;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (e_fire && e_flags_reg.decide)
                left_reg <= center;
        end
    end

    assign out_valid = out_valid_reg;
    assign peak_row  = peak_row_reg;
    assign peak_col  = peak_col_reg;

    a_issue_loads: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> e_valid_reg)
        else $error("issued request lost before execute");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && !out_free |=> e_valid_reg && $stable(e_col_reg) && $stable(e_row_reg))
        else $error("execute stage changed while the result was blocked");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall
        |=> out_valid_reg && $stable(peak_row_reg) && $stable(peak_col_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/grid_local_maximum_finder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_local_maximum_finder: streams one grid with random
// sizes and idling, predicts every 4-neighbor peak and checks each reported position.
// Depends on glmf_pkg and the RTL top level only.

module grid_local_maximum_finder_test;

    localparam int CLK_PERIOD     = 12;
    localparam int COL_BITS       = $clog2(glmf_pkg::MAX_COLS);
    localparam int SB             = glmf_pkg::SAMPLE_BITS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 800000;

    typedef struct packed {
        logic [glmf_pkg::ROW_BITS-1:0] row;
        logic [COL_BITS-1:0]           col;
    } peak_t;

    logic                               clk;
    logic                               rst_n       = 1'b0;
    logic                               cfg_we      = 1'b0;
    logic [glmf_pkg::CFG_IDX_BITS-1:0]  cfg_index   = '0;
    logic [glmf_pkg::CFG_DATA_BITS-1:0] cfg_data    = '0;
    logic                               in_valid    = 1'b0;
    logic                               in_stall;
    logic                               command     = glmf_pkg::CMD_SAMPLE;
    logic [SB-1:0]                      pixel_value = '0;
    logic                               out_valid;
    logic                               out_stall   = 1'b0;
    logic [glmf_pkg::ROW_BITS-1:0]      peak_row;
    logic [COL_BITS-1:0]                peak_col;

    // Grid tracker state
    logic [glmf_pkg::NUM_ROWS_BITS-1:0] rows_reg;
    logic [glmf_pkg::NUM_COLS_BITS-1:0] cols_reg;
    logic signed [SB-1:0]               prev_line  [glmf_pkg::MAX_COLS];
    logic signed [SB-1:0]               older_line [glmf_pkg::MAX_COLS];
    logic signed [SB-1:0]               left_value;
    int                                 row_pos;
    int                                 col_pos;
    glmf_pkg::phase_t                   grid_phase;

    peak_t peaks_due [$];
    int    error_count     = 0;
    int    requests_sent   = 0;
    int    peaks_checked   = 0;
    int    register_writes = 0;
    bit    tx_calm         = 1'b0;

    grid_local_maximum_finder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .peak_row    (peak_row),
        .peak_col    (peak_col)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int eff_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > glmf_pkg::ROWS_LIMIT)
            return glmf_pkg::ROWS_LIMIT;
        return int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > glmf_pkg::MAX_COLS)
            return glmf_pkg::MAX_COLS;
        return int'(cols_reg);
    endfunction

    // Decide one cell of the completed row; shifts it into the older line.
    function automatic bit is_peak(input int c, input int cols, input bit has_up,
                                   input bit has_down,
                                   input logic signed [SB-1:0] below);
        logic signed [SB-1:0] center;
        bit peak;
        center = prev_line[c];
        peak   = 1'b1;
        if (c > 0 && center < left_value)
            peak = 1'b0;
        if (c + 1 < cols)
        begin
            if (center < prev_line[c + 1])
                peak = 1'b0;
        end
        if (has_up && center < older_line[c])
            peak = 1'b0;
        if (has_down && center < below)
            peak = 1'b0;
        older_line[c] = center;
        left_value    = center;
        return peak;
    endfunction

    task automatic clear_grid();
        rows_reg   = glmf_pkg::NUM_ROWS_BITS'(1);
        cols_reg   = glmf_pkg::NUM_COLS_BITS'(1);
        left_value = '0;
        row_pos    = 0;
        col_pos    = 0;
        grid_phase = glmf_pkg::PH_LOAD;
        foreach (prev_line[i])
        begin
            prev_line[i]  = '0;
            older_line[i] = '0;
        end
    endtask

    task automatic advance_grid(input logic cmd, input logic [SB-1:0] value);
        int    rows;
        int    cols;
        int    r;
        int    c;
        bit    last_col;
        bit    last_row;
        peak_t hit;
        rows = eff_rows();
        cols = eff_cols();
        r    = (row_pos > rows - 1) ? rows - 1 : row_pos;
        c    = (col_pos > cols - 1) ? cols - 1 : col_pos;
        last_col = (c == cols - 1);
        last_row = (r == rows - 1);
        if (grid_phase == glmf_pkg::PH_LOAD && cmd == glmf_pkg::CMD_SAMPLE)
        begin
            if (r > 0)
            begin
                if (is_peak(c, cols, r >= 2, 1'b1, value))
                begin
                    hit.row = glmf_pkg::ROW_BITS'(r - 1);
                    hit.col = COL_BITS'(c);
                    peaks_due.push_back(hit);
                end
            end
            prev_line[c] = value;
            row_pos = r;
            if (last_col)
            begin
                col_pos = 0;
                if (last_row)
                    grid_phase = glmf_pkg::PH_FLUSH;
                else
                    row_pos = r + 1;
            end
            else
                col_pos = c + 1;
        end
        else if (grid_phase == glmf_pkg::PH_FLUSH && cmd == glmf_pkg::CMD_FLUSH)
        begin
            if (is_peak(c, cols, r > 0, 1'b0, '0))
            begin
                hit.row = glmf_pkg::ROW_BITS'(r);
                hit.col = COL_BITS'(c);
                peaks_due.push_back(hit);
            end
            row_pos = r;
            if (last_col)
            begin
                col_pos    = 0;
                grid_phase = glmf_pkg::PH_DONE;
            end
            else
                col_pos = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int pick_gap();
        int roll;
        if (tx_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SB-1:0] pick_pixel();
        logic [SB-1:0] v;
        int mode;
        mode = $urandom_range(0, 9);
        v = SB'($urandom);
        if (mode >= 5 && mode <= 7)
        begin
            // narrow range: plenty of ties
            v = SB'($urandom_range(0, 4));
            v = v - SB'(2);
        end
        else if (mode == 8)
            v = {1'b0, {(SB - 1){1'b1}}};
        else if (mode == 9)
            v = {1'b1, {(SB - 1){1'b0}}};
        return v;
    endfunction

    // Send one request; valid stays high after acceptance so back-to-back
    // requests need no second assignment in the same step.
    task automatic send_request(input logic cmd, input logic [SB-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        pixel_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        advance_grid(cmd, value);
    endtask

    // Send the wanted command, or now and then the other one as noise.
    task automatic send_mixed(input logic main_cmd, input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            send_request(~main_cmd, pick_pixel());
        else
            send_request(main_cmd, pick_pixel());
    endtask

    task automatic wait_for_peaks(input int settle);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (peaks_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [glmf_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [glmf_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == glmf_pkg::REG_NUM_ROWS)
            rows_reg = value[glmf_pkg::NUM_ROWS_BITS-1:0];
        else
            cols_reg = value[glmf_pkg::NUM_COLS_BITS-1:0];
        register_writes++;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_peaks
        peak_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (peaks_due.size() == 0)
                report_mismatch($sformatf("unexpected peak at row %0d col %0d",
                                          peak_row, peak_col));
            else
            begin
                due = peaks_due.pop_front();
                peaks_checked++;
                if (peak_row !== due.row)
                    report_mismatch($sformatf("peak_row %0d, wanted %0d (col %0d)",
                                              peak_row, due.row, due.col));
                if (peak_col !== due.col)
                    report_mismatch($sformatf("peak_col %0d, wanted %0d (row %0d)",
                                              peak_col, due.col, due.row));
            end
        end
    end

    // Receiver: runs of acceptance broken by short, long or no stalls.
    initial
    begin : drive_out_stall
        int run;
        int roll;
        forever
        begin
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
            roll = $urandom_range(0, 9);
            if (roll < 2)
                run = 0;
            else if (roll < 9)
                run = $urandom_range(1, 3);
            else
                run = $urandom_range(8, 40);
            repeat (run)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    // A flush tick while loading is dropped; then open up to oversized registers.
    task automatic test_ignored_flush_and_oversize();
        send_request(glmf_pkg::CMD_FLUSH, 16'h1234);
        wait_for_peaks(SETTLE_CYCLES);
        write_register(glmf_pkg::REG_NUM_ROWS, 13'h1FFF);
        write_register(glmf_pkg::REG_NUM_COLS, 13'h00FF);
    endtask

    task automatic test_sample_extremes();
        logic [SB-1:0] extremes [16] = '{
            16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h8000,
            16'h8000, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C, 16'h7FFE, 16'h8001, 16'hAAAA
        };
        tx_calm = 1'b0;
        foreach (extremes[i])
        begin
            if (i == 3 || i == 10)
                send_request(glmf_pkg::CMD_FLUSH, 16'h5555);
            send_request(glmf_pkg::CMD_SAMPLE, extremes[i]);
        end
    endtask

    // Fill both line stores at full width so later size changes never read
    // an entry that was not written.
    task automatic test_fill_line_stores();
        bit paused;
        paused  = 1'b0;
        tx_calm = ($urandom_range(0, 3) == 0);
        while (!(row_pos == 2 && col_pos == 0))
        begin
            if (!paused && row_pos == 1 && col_pos == 64)
            begin
                // hold the sender until every predicted peak has been reported
                wait_for_peaks(1);
                paused  = 1'b1;
                tx_calm = ~tx_calm;
            end
            send_mixed(glmf_pkg::CMD_SAMPLE, 5);
        end
    endtask

    task automatic test_size_changes();
        int cols_val;
        int rows_val;
        int count;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_for_peaks(SETTLE_CYCLES);
            case (ph)
                0: cols_val = 1;
                1: cols_val = 0;
                2: cols_val = glmf_pkg::MAX_COLS;
                3: cols_val = 2;
                4: cols_val = $urandom_range(1, 255);
                default: cols_val = $urandom_range(3, glmf_pkg::MAX_COLS - 1);
            endcase
            case (ph)
                0: rows_val = glmf_pkg::ROWS_LIMIT;
                1: rows_val = 8191;
                2: rows_val = $urandom_range(row_pos + 64, glmf_pkg::ROWS_LIMIT - 1);
                3: rows_val = $urandom_range(glmf_pkg::ROWS_LIMIT + 1, 8191);
                default: rows_val = $urandom_range(row_pos + 64, 8191);
            endcase
            if ($urandom_range(0, 1))
            begin
                write_register(glmf_pkg::REG_NUM_COLS, glmf_pkg::CFG_DATA_BITS'(cols_val));
                write_register(glmf_pkg::REG_NUM_ROWS, glmf_pkg::CFG_DATA_BITS'(rows_val));
            end
            else
            begin
                write_register(glmf_pkg::REG_NUM_ROWS, glmf_pkg::CFG_DATA_BITS'(rows_val));
                write_register(glmf_pkg::REG_NUM_COLS, glmf_pkg::CFG_DATA_BITS'(cols_val));
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(12, 30);
            repeat (count) send_mixed(glmf_pkg::CMD_SAMPLE, 10);
        end
    endtask

    // Shrink the row count so the current or an earlier row becomes the last,
    // flush the bottom row, then feed the finished grid a few stray requests.
    task automatic test_bottom_row();
        int rows_val;
        wait_for_peaks(SETTLE_CYCLES);
        case ($urandom_range(0, 3))
            0: rows_val = 0;
            1: rows_val = 1;
            2: rows_val = row_pos;
            default: rows_val = row_pos + 1;
        endcase
        if ($urandom_range(0, 1))
            write_register(glmf_pkg::REG_NUM_COLS,
                           glmf_pkg::CFG_DATA_BITS'($urandom_range(1, 20)));
        write_register(glmf_pkg::REG_NUM_ROWS, glmf_pkg::CFG_DATA_BITS'(rows_val));
        tx_calm = ($urandom_range(0, 3) == 0);
        while (grid_phase == glmf_pkg::PH_LOAD)
            send_mixed(glmf_pkg::CMD_SAMPLE, 10);
        while (grid_phase == glmf_pkg::PH_FLUSH)
            send_mixed(glmf_pkg::CMD_FLUSH, 15);
        repeat (5) send_mixed(glmf_pkg::CMD_SAMPLE, 50);
    endtask

    initial
    begin
        clear_grid();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_flush_and_oversize();
        test_sample_extremes();
        test_fill_line_stores();
        test_size_changes();
        test_bottom_row();

        wait_for_peaks(SETTLE_CYCLES);
        if (peaks_due.size() != 0)
            report_mismatch($sformatf("%0d peaks never reported", peaks_due.size()));

        $display("Run covered %0d requests, %0d peaks checked, %0d register writes.",
                 requests_sent, peaks_checked, register_writes);
        $display("Grid ended at row %0d with %0d x %0d in use.",
                 row_pos, eff_rows(), eff_cols());
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
